@@ design/bced_pkg.sv @@
// Shared types and codes for the button click event detector.
package bced_pkg;

	localparam int unsigned TickW   = 16;
	localparam int unsigned RepeatW = 8;
	localparam int unsigned BounceW = 3;
	localparam int unsigned CfgIdxW = 2;
	localparam int unsigned CfgW    = 16;

	// Configuration register indexes
	typedef enum logic [CfgIdxW-1:0] {
		CFG_ACTIVE_LEVEL = 2'd0,
		CFG_BOUNCE_LIMIT = 2'd1,
		CFG_CLICK_GAP    = 2'd2,
		CFG_HOLD_LIMIT   = 2'd3
	} cfg_idx_t;

	// Event codes as reported in last_event
	typedef enum logic [2:0] {
		EV_DOWN   = 3'd0,
		EV_UP     = 3'd1,
		EV_REPEAT = 3'd2,
		EV_SINGLE = 3'd3,
		EV_DOUBLE = 3'd4,
		EV_LSTART = 3'd5,
		EV_HOLD   = 3'd6,
		EV_NONE   = 3'd7
	} event_t;

	typedef struct packed {
		logic press_down;
		logic press_up;
		logic repeat_press;
		logic single_click;
		logic double_click;
		logic long_start;
		logic long_hold;
	} flags_t;

	typedef struct packed {
		logic [TickW-1:0] click_gap;
		logic [TickW-1:0] hold_limit;
	} timing_cfg_t;

	typedef struct packed {
		flags_t               flags;
		event_t               last_event;
		logic [RepeatW-1:0]   repeat_count;
	} click_result_t;

endpackage

@@ design/bced_if.sv @@
// Request channel interfaces for raw levels in and click results out.
interface bced_in_if;
	logic valid;
	logic ready;
	logic raw_level;

	modport source (output valid, output raw_level, input ready);
	modport sink (input valid, input raw_level, output ready);
endinterface

interface bced_out_if;
	logic       valid;
	logic       ready;
	logic       fired_press_down;
	logic       fired_press_up;
	logic       fired_repeat;
	logic       fired_single_click;
	logic       fired_double_click;
	logic       fired_long_start;
	logic       fired_long_hold;
	logic [2:0] last_event;
	logic [7:0] repeat_count;
	logic       stable_level;

	modport source (
		output valid, input ready,
		output fired_press_down, output fired_press_up, output fired_repeat,
		output fired_single_click, output fired_double_click,
		output fired_long_start, output fired_long_hold,
		output last_event, output repeat_count, output stable_level
	);
	modport sink (
		input valid, output ready,
		input fired_press_down, input fired_press_up, input fired_repeat,
		input fired_single_click, input fired_double_click,
		input fired_long_start, input fired_long_hold,
		input last_event, input repeat_count, input stable_level
	);
endinterface

@@ design/button_click_event_detector.sv @@
// Top level of the single-button click and long-press event detector.
//
// Each input request carries one scan tick's raw button level and produces
// exactly one result request: the seven event flags raised on that tick, the
// last event code, the press count of the current click sequence and the
// debounced level. A request lands in an input register, the debouncer and
// the click state machine evaluate it in one short combinational pass, and
// the outcome is written to a result register. One request is taken every
// clock cycle unless a stalled sink holds both registers full.
// The result register holds a finished result while the next raw
// level already waits in the input register, so a stalled sink only stops
// intake once both registers are full. Configuration is written through a
// plain write port (index 0 active level, 1 debounce length, 2 click gap
// limit, 3 long press limit) and takes effect for ticks processed afterwards;
// write it only while no request is in flight.
module button_click_event_detector
	import bced_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	bced_in_if.sink            in_ch,
	bced_out_if.source         out_ch,
	input  logic               cfg_we,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [CfgW-1:0]    cfg_data
);

	// Configuration registers
	logic               active_level_q;
	logic [BounceW-1:0] bounce_limit_q;
	timing_cfg_t        timing_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_level_q      <= 1'b0;
			bounce_limit_q      <= BounceW'(3);
			timing_q.click_gap  <= TickW'(60);
			timing_q.hold_limit <= TickW'(200);
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_ACTIVE_LEVEL: active_level_q      <= cfg_data[0];
				CFG_BOUNCE_LIMIT: bounce_limit_q      <= cfg_data[BounceW-1:0];
				CFG_CLICK_GAP:    timing_q.click_gap  <= cfg_data[TickW-1:0];
				CFG_HOLD_LIMIT:   timing_q.hold_limit <= cfg_data[TickW-1:0];
				default: ;
			endcase
		end
	end

	// Input register: hold one raw level until the step can run
	logic valid_s1;
	logic raw_s1;
	logic step;
	logic out_valid_q;

	// Advance the tick when the result register is free or being drained
	assign step         = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready  = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			raw_s1 <= in_ch.raw_level;
		end
	end

	// One tick of work: debounce, then run the click machine on the new level
	logic          level_next;
	click_result_t result;

	bced_debounce u_debounce (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.raw_level    (raw_s1),
		.bounce_limit (bounce_limit_q),
		.level_next   (level_next)
	);

	bced_click_fsm u_click_fsm (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.pressed (level_next == active_level_q),
		.timing  (timing_q),
		.result  (result)
	);

	// Result register: hold the finished request until the sink takes it
	click_result_t result_q;
	logic          stable_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			result_q <= result;
			stable_q <= level_next;
		end
	end

	assign out_ch.valid              = out_valid_q;
	assign out_ch.fired_press_down   = result_q.flags.press_down;
	assign out_ch.fired_press_up     = result_q.flags.press_up;
	assign out_ch.fired_repeat       = result_q.flags.repeat_press;
	assign out_ch.fired_single_click = result_q.flags.single_click;
	assign out_ch.fired_double_click = result_q.flags.double_click;
	assign out_ch.fired_long_start   = result_q.flags.long_start;
	assign out_ch.fired_long_hold    = result_q.flags.long_hold;
	assign out_ch.last_event         = result_q.last_event;
	assign out_ch.repeat_count       = result_q.repeat_count;
	assign out_ch.stable_level       = stable_q;

endmodule

@@ design/bced_debounce.sv @@
// Debouncer: accepts a new level after enough consecutive differing ticks.
module bced_debounce
	import bced_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic               raw_level,
	input  logic [BounceW-1:0] bounce_limit,
	output logic               level_next
);

	logic [BounceW-1:0] bounce_q;
	logic               level_q;
	logic [BounceW-1:0] bounce_inc;
	logic [BounceW-1:0] bounce_next;

	always_comb begin
		bounce_inc  = bounce_q + BounceW'(1);
		bounce_next = '0;
		level_next  = level_q;
		if (raw_level != level_q) begin
			if (bounce_inc >= bounce_limit) begin
				level_next  = raw_level;
			end else begin
				bounce_next = bounce_inc;
			end
		end
	end

	// Reset level is the inverse of the reset active level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bounce_q <= '0;
			level_q  <= 1'b1;
		end else if (step) begin
			bounce_q <= bounce_next;
			level_q  <= level_next;
		end
	end

endmodule

@@ design/bced_click_fsm.sv @@
// Click state machine: turns the debounced level into click events.
module bced_click_fsm
	import bced_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  logic          pressed,
	input  timing_cfg_t   timing,
	output click_result_t result
);

	typedef enum logic [2:0] {
		ST_IDLE     = 3'd0,
		ST_PRESSED  = 3'd1,
		ST_RELEASED = 3'd2,
		ST_REPEAT   = 3'd3,
		ST_LONG     = 3'd5
	} state_t;

	state_t             state_q, state_next;
	logic [TickW-1:0]   tick_q, tick_inc, tick_next;
	logic [RepeatW-1:0] repeats_q, repeats_next;
	event_t             recent_q, recent_next;
	flags_t             flags;

	always_comb begin
		tick_inc     = (state_q != ST_IDLE) ? tick_q + TickW'(1) : tick_q;
		tick_next    = tick_inc;
		state_next   = state_q;
		repeats_next = repeats_q;
		recent_next  = recent_q;
		flags        = '0;
		case (state_q)
			ST_IDLE: begin
				if (pressed) begin
					flags.press_down = 1'b1;
					recent_next      = EV_DOWN;
					tick_next        = '0;
					repeats_next     = RepeatW'(1);
					state_next       = ST_PRESSED;
				end else begin
					recent_next = EV_NONE;
				end
			end
			ST_PRESSED: begin
				if (!pressed) begin
					flags.press_up = 1'b1;
					recent_next    = EV_UP;
					tick_next      = '0;
					state_next     = ST_RELEASED;
				end else if (tick_inc > timing.hold_limit) begin
					flags.long_start = 1'b1;
					recent_next      = EV_LSTART;
					state_next       = ST_LONG;
				end
			end
			ST_RELEASED: begin
				if (pressed) begin
					flags.press_down   = 1'b1;
					flags.repeat_press = 1'b1;
					recent_next        = EV_REPEAT;
					repeats_next       = repeats_q + RepeatW'(1);
					tick_next          = '0;
					state_next         = ST_REPEAT;
				end else if (tick_inc > timing.click_gap) begin
					if (repeats_q == RepeatW'(1)) begin
						flags.single_click = 1'b1;
						recent_next        = EV_SINGLE;
					end else if (repeats_q == RepeatW'(2)) begin
						flags.double_click = 1'b1;
						recent_next        = EV_DOUBLE;
					end
					state_next = ST_IDLE;
				end
			end
			ST_REPEAT: begin
				if (!pressed) begin
					flags.press_up = 1'b1;
					recent_next    = EV_UP;
					if (tick_inc < timing.click_gap) begin
						tick_next  = '0;
						state_next = ST_RELEASED;
					end else begin
						state_next = ST_IDLE;
					end
				end else if (tick_inc > timing.hold_limit) begin
					state_next = ST_PRESSED;
				end
			end
			ST_LONG: begin
				if (pressed) begin
					flags.long_hold = 1'b1;
					recent_next     = EV_HOLD;
				end else begin
					flags.press_up = 1'b1;
					recent_next    = EV_UP;
					state_next     = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			tick_q    <= '0;
			repeats_q <= '0;
			recent_q  <= EV_NONE;
		end else if (step) begin
			state_q   <= state_next;
			tick_q    <= tick_next;
			repeats_q <= repeats_next;
			recent_q  <= recent_next;
		end
	end

	assign result.flags        = flags;
	assign result.last_event   = recent_next;
	assign result.repeat_count = repeats_next;

endmodule
